// ----- rtl/core/bftr_pkg.sv -----
`default_nettype none

package bftr_pkg;

  localparam int FrameLength = 138;

  localparam logic [7:0] StartupFirst = 8'd10;
  localparam logic [7:0] GpsFirst     = 8'd18;
  localparam logic [7:0] StampBytes   = 8'd8;
  localparam logic [7:0] CrcHiPos     = 8'(FrameLength - 2);
  localparam logic [7:0] LastPos      = 8'(FrameLength - 1);

  localparam logic [31:0] TimeStepReset = 32'd2500000;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] crc_t;
  typedef logic [63:0] stamp_t;
  typedef logic [31:0] step_t;

  typedef enum logic [1:0] {
    RegStartupTime = 2'd0,
    RegGpsTime     = 2'd1,
    RegTimeStep    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    byte_t out_byte;
    logic  frame_end;
  } out_item_t;

  function automatic crc_t crc_add_byte(crc_t crc, byte_t b);
    crc_t c;
    c = {crc[7:0], crc[15:8]} ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bftr_in_if.sv -----
`default_nettype none

interface bftr_in_if;
  import bftr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t template_byte;

  modport source (output valid, output template_byte, input ready);
  modport sink (input valid, input template_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bftr_out_if.sv -----
`default_nettype none

interface bftr_out_if;
  import bftr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bftr_cfg_if.sv -----
`default_nettype none

interface bftr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bftr_obuf.sv -----
`default_nettype none

module bftr_obuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  input  wire bftr_pkg::out_item_t push_item,
  output      logic               push_ready,
  bftr_out_if.source              out_ch
);
  import bftr_pkg::*;

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;
  logic      push;

  assign push_ready = !skid_valid_r;
  assign push       = push_valid && push_ready;
  assign pop        = main_valid_r && out_ch.ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_item;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_item;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid     = main_valid_r;
  assign out_ch.out_byte  = main_r.out_byte;
  assign out_ch.frame_end = main_r.frame_end;

endmodule

`default_nettype wire

// ----- rtl/core/binary_frame_timestamp_restamper.sv -----
// Each accepted byte is registered in the output buffer before it is offered.
// Throughput: one byte per cycle while the output takes each byte; the two-entry
// output buffer keeps the input open while one result waits to be taken.
// Reset (synchronous, rst_n low): position, CRC and both running timestamps clear
// to zero, the time step loads 2500000, the output buffer empties.
`default_nettype none

module binary_frame_timestamp_restamper (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bftr_in_if.sink    in_ch,
  bftr_out_if.source out_ch,
  bftr_cfg_if.sink   cfg_ch
);
  import bftr_pkg::*;

  logic [7:0] pos_r, pos_nxt;
  crc_t       crc_r, crc_nxt;
  stamp_t     startup_r, startup_nxt;
  stamp_t     gps_r, gps_nxt;
  step_t      step_r, step_nxt;
  out_item_t  item;
  logic       buf_ready;
  logic       acc;
  logic       cfg_acc;
  logic [7:0] st_off;
  logic [7:0] gps_off;

  assign in_ch.ready  = buf_ready;
  assign cfg_ch.ready = 1'b1;
  assign acc          = in_ch.valid && buf_ready;
  assign cfg_acc      = cfg_ch.valid;

  assign st_off  = pos_r - StartupFirst;
  assign gps_off = pos_r - GpsFirst;

  always_comb begin
    item.out_byte  = in_ch.template_byte;
    item.frame_end = 1'b0;
    if (pos_r >= StartupFirst && pos_r < StartupFirst + StampBytes) begin
      item.out_byte = startup_r[{st_off[2:0], 3'b000} +: 8];
    end else if (pos_r >= GpsFirst && pos_r < GpsFirst + StampBytes) begin
      item.out_byte = gps_r[{gps_off[2:0], 3'b000} +: 8];
    end else if (pos_r == CrcHiPos) begin
      item.out_byte = crc_r[15:8];
    end else if (pos_r >= LastPos) begin
      item.out_byte  = crc_r[7:0];
      item.frame_end = 1'b1;
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    startup_nxt = startup_r;
    gps_nxt     = gps_r;
    step_nxt    = step_r;
    if (acc) begin
      if (pos_r >= 8'd1 && pos_r < CrcHiPos) begin
        crc_nxt = crc_add_byte(crc_r, item.out_byte);
      end
      if (item.frame_end) begin
        startup_nxt = startup_r + {32'h0, step_r};
        gps_nxt     = gps_r + {32'h0, step_r};
        crc_nxt     = '0;
        pos_nxt     = '0;
      end else begin
        pos_nxt = pos_r + 8'd1;
      end
    end
    if (cfg_acc) begin
      unique case (cfg_ch.index)
        RegStartupTime: startup_nxt = cfg_ch.data;
        RegGpsTime:     gps_nxt     = cfg_ch.data;
        RegTimeStep:    step_nxt    = cfg_ch.data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      crc_r     <= '0;
      startup_r <= '0;
      gps_r     <= '0;
      step_r    <= TimeStepReset;
    end else begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      startup_r <= startup_nxt;
      gps_r     <= gps_nxt;
      step_r    <= step_nxt;
    end
  end

  bftr_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_item  (item),
    .push_ready (buf_ready),
    .out_ch     (out_ch)
  );

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LastPos)
    else $error("frame position out of range");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && pos_r == LastPos |=> pos_r == 8'd0 && crc_r == 16'h0000)
    else $error("frame did not restart after last byte");

  a_crc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 8'd1 |-> crc_r == 16'h0000)
    else $error("CRC not clear at frame start");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire

// ----- tb/bftr_restamp_check.sv -----
module bftr_restamp_check (
  input  logic        clk,
  input  logic        rst_n,
  bftr_in_if          in_mon,
  bftr_out_if         out_mon,
  bftr_cfg_if         cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import bftr_pkg::*;

  localparam crc_t CcittPoly = 16'h1021;

  stamp_t    startup_stamp;
  stamp_t    gps_stamp;
  step_t     stamp_step;
  crc_t      frame_crc;
  byte_t     frame_pos;
  out_item_t restamped_bytes[$];

  function automatic crc_t ccitt_update(crc_t crc, byte_t b);
    crc_t c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CcittPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic out_item_t restamp_byte(byte_t tmpl);
    out_item_t r;
    r.out_byte  = tmpl;
    r.frame_end = 1'b0;
    if (frame_pos >= StartupFirst && frame_pos < StartupFirst + StampBytes) begin
      r.out_byte = startup_stamp[{3'(frame_pos - StartupFirst), 3'b000} +: 8];
    end else if (frame_pos >= GpsFirst && frame_pos < GpsFirst + StampBytes) begin
      r.out_byte = gps_stamp[{3'(frame_pos - GpsFirst), 3'b000} +: 8];
    end else if (frame_pos == CrcHiPos) begin
      r.out_byte = frame_crc[15:8];
    end else if (frame_pos >= LastPos) begin
      r.out_byte  = frame_crc[7:0];
      r.frame_end = 1'b1;
    end
    if (frame_pos >= 8'd1 && frame_pos < CrcHiPos) begin
      frame_crc = ccitt_update(frame_crc, r.out_byte);
    end
    if (r.frame_end) begin
      startup_stamp = startup_stamp + {32'h0, stamp_step};
      gps_stamp     = gps_stamp + {32'h0, stamp_step};
      frame_crc     = '0;
      frame_pos     = '0;
    end else begin
      frame_pos = frame_pos + 8'd1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      startup_stamp = '0;
      gps_stamp     = '0;
      stamp_step    = TimeStepReset;
      frame_crc     = '0;
      frame_pos     = '0;
      restamped_bytes.delete();
      fail_count    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.index))
          RegStartupTime: startup_stamp = cfg_mon.data;
          RegGpsTime:     gps_stamp = cfg_mon.data;
          RegTimeStep:    stamp_step = cfg_mon.data[31:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        restamped_bytes.push_back(restamp_byte(in_mon.template_byte));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (restamped_bytes.size() == 0) begin
          $error("unexpected transaction: out_byte 0x%02h frame_end %0b",
                 out_mon.out_byte, out_mon.frame_end);
          fail_count++;
        end else begin
          want = restamped_bytes.pop_front();
          if (out_mon.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                   want.out_byte, out_mon.out_byte);
            fail_count++;
          end
          if (out_mon.frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, actual %0b",
                   want.frame_end, out_mon.frame_end);
            fail_count++;
          end
        end
      end
    end
    pending = restamped_bytes.size();
  end

endmodule

// ----- tb/tb_binary_frame_timestamp_restamper.sv -----
module tb_binary_frame_timestamp_restamper;
  timeunit 1ns;
  timeprecision 1ps;

  import bftr_pkg::*;

  localparam int unsigned ItemTarget  = 1300;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 200;
  localparam logic [1:0]  UnusedIndex = 2'd3;

  typedef enum logic [1:0] {
    FillRandom,
    FillOnes,
    FillZeros,
    FillAlternate
  } fill_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        pressure_on;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  bftr_in_if  in_ch ();
  bftr_out_if out_ch ();
  bftr_cfg_if cfg_ch ();

  binary_frame_timestamp_restamper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bftr_restamp_check restamp_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[binary_frame_timestamp_restamper] ERROR");
      $finish;
    end
  end

  function automatic stamp_t pick_stamp();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return stamp_t'('1) - stamp_t'($urandom_range(0, 200000000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic stamp_t pick_step();
    step_t s;
    case ($urandom_range(0, 4))
      0:       s = '0;
      1:       s = '1;
      2:       s = TimeStepReset;
      default: s = $urandom;
    endcase
    return {32'($urandom), s};
  endfunction

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input stamp_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_run(input int unsigned count, input fill_t fill, input bit gapless);
    byte_t       b;
    int unsigned roll;
    int unsigned gap;
    for (int unsigned i = 0; i < count; i++) begin
      case (fill)
        FillOnes:      b = 8'hFF;
        FillZeros:     b = 8'h00;
        FillAlternate: b = i[0] ? 8'hFF : 8'h00;
        default:       b = byte_t'($urandom);
      endcase
      roll = $urandom_range(0, 19);
      if (gapless || roll > 5) begin
        gap = 0;
      end else if (roll == 0) begin
        gap = $urandom_range(8, 40);
      end else begin
        gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid         <= 1'b1;
      in_ch.template_byte <= b;
      do @(posedge clk); while (!in_ch.ready);
      items_sent++;
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned stall_left;
    int unsigned roll;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        roll = $urandom_range(0, 49);
        if (roll == 0) begin
          stall_left = $urandom_range(10, 40);
        end else if (roll <= 6) begin
          stall_left = $urandom_range(1, 3);
        end
      end else begin
        stall_left--;
      end
      out_ch.ready <= !pressure_on && stall_left == 0;
    end
  end

  // hold the output off while the sender keeps offering
  initial begin
    pressure_on = 1'b0;
    wait (items_sent >= 300);
    @(negedge clk);
    pressure_on <= 1'b1;
    repeat (HoldCycles) @(negedge clk);
    pressure_on <= 1'b0;
    wait (items_sent >= 900);
    @(negedge clk);
    pressure_on <= 1'b1;
    repeat (HoldCycles) @(negedge clk);
    pressure_on <= 1'b0;
  end

  initial begin
    int unsigned n_writes;
    logic [1:0]  idx;
    int unsigned run_len;
    fill_t       fill;
    in_ch.valid         = 1'b0;
    in_ch.template_byte = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = RegStartupTime;
    cfg_ch.data         = '0;
    rst_n               = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_run(14, FillOnes, 1'b0);
    wait_drained();
    write_reg(RegStartupTime, stamp_t'('1) - 64'd5);
    write_reg(RegGpsTime, '1);
    write_reg(RegTimeStep, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
    write_reg(UnusedIndex, {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
    send_run(12, FillZeros, 1'b0);

    while (items_sent < ItemTarget) begin
      wait_drained();
      n_writes = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      for (int unsigned w = 0; w < n_writes; w++) begin
        idx = 2'($urandom_range(0, 3));
        if (idx == RegTimeStep) begin
          write_reg(idx, pick_step());
        end else if (idx == UnusedIndex) begin
          write_reg(idx, {$urandom, $urandom});
        end else begin
          write_reg(idx, pick_stamp());
        end
      end
      cfg_ch.valid <= 1'b0;
      run_len = ($urandom_range(0, 3) != 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      if (run_len > ItemTarget - items_sent) begin
        run_len = ItemTarget - items_sent;
      end
      case ($urandom_range(0, 7))
        0:       fill = FillOnes;
        1:       fill = FillZeros;
        2:       fill = FillAlternate;
        default: fill = FillRandom;
      endcase
      send_run(run_len, fill, $urandom_range(0, 4) == 0);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[binary_frame_timestamp_restamper] OK");
    end else begin
      $display("[binary_frame_timestamp_restamper] ERROR");
    end
    $finish;
  end

endmodule
